### rtl/core/ccec_pkg.sv
package ccec_pkg;

    // Field widths of the request and result channels
    localparam int PROB_W = 17;
    localparam int MASS_W = 25;
    localparam int COST_W = 31;
    localparam int IDX_W  = 5;

    // Probability fields carried by one request, and the widest color count
    localparam int PROB_FIELDS = 3;
    localparam int MAX_COLORS  = 4;

    // Rounding from the product scale (Q1.16 x Q1.24) down to Q1.24
    localparam int ROUND_SHIFT = 16;
    localparam int ROUND_HALF  = 32768;

    typedef logic [PROB_W-1:0] prob_t;
    typedef logic [MASS_W-1:0] mass_t;
    typedef logic [COST_W-1:0] cost_t;
    typedef logic [IDX_W-1:0]  idx_t;

    localparam prob_t PROB_ONE = 17'd65536;
    localparam mass_t MASS_ONE = 25'd16777216;
    localparam cost_t COST_ONE = 31'd16777216;
    localparam cost_t COST_MAX = 31'd1073741824;

    // Request commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_APPLY = 1'b1;

endpackage

### rtl/core/ccec_ram.sv
module ccec_ram #(
    parameter int WIDTH  = 51,
    parameter int DEPTH  = 20,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write one row, register the read row
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/ccec_step.sv
module ccec_step #(
    parameter int COLORS = 3
) (
    input  ccec_pkg::prob_t [COLORS-1:0]     prob,
    input  ccec_pkg::mass_t [2**COLORS-1:0]  mass_in,
    input  ccec_pkg::cost_t                  cost_in,
    output ccec_pkg::mass_t [2**COLORS-1:0]  mass_out,
    output ccec_pkg::cost_t                  cost_out
);

    import ccec_pkg::*;

    localparam int SUBSETS = 2**COLORS;
    localparam int SUB_W   = COLORS;
    // Product of a Q1.16 probability and a sum of two Q1.24 masses, plus headroom
    // for up to COLORS terms
    localparam int PROD_W  = PROB_W + MASS_W + 1;
    localparam int ACC_W   = PROD_W + $clog2(COLORS) + 1;
    // Cost plus every unfinished mass never reaches 2^32
    localparam int CSUM_W  = COST_W + 1;

    // Advance the subset chain by one test and grow the cost
    always_comb begin
        logic [ACC_W-1:0]  acc;
        logic [ACC_W-1:0]  rnd;
        logic [SUB_W-1:0]  sidx;
        logic [SUB_W-1:0]  pidx;
        logic [MASS_W:0]   pair;
        logic [CSUM_W-1:0] csum;
        csum = CSUM_W'(cost_in);
        mass_out = '0;
        for (int s = 1; s < SUBSETS; s++) begin
            sidx = SUB_W'(s);
            acc  = '0;
            for (int c = 0; c < COLORS; c++) begin
                if (sidx[c]) begin
                    pidx = sidx ^ (SUB_W'(1) << c);
                    pair = {1'b0, mass_in[pidx]} + {1'b0, mass_in[sidx]};
                    acc  = acc + ACC_W'(prob[c]) * ACC_W'(pair);
                end
            end
            // Round once to Q1.24 and clamp at one
            rnd = (acc + ACC_W'(ROUND_HALF)) >> ROUND_SHIFT;
            mass_out[s] = (rnd > ACC_W'(MASS_ONE)) ? MASS_ONE : rnd[MASS_W-1:0];
            // Only unfinished subsets add to the cost
            if (s != SUBSETS - 1) begin
                csum = csum + CSUM_W'(mass_out[s]);
            end
        end
        cost_out = (csum > CSUM_W'(COST_MAX)) ? COST_MAX : csum[COST_W-1:0];
    end

endmodule

### rtl/core/coupon_chain_expected_cost_core.sv
// Scores one test order for the coupon-collector chain. A load request
// (command 0) writes one test's color probabilities into the table and
// returns nothing; an apply request (command 1) advances the subset-mass
// chain by that test and returns the running expected cost and the mass of
// the all-colors subset. The table row is read into its register at the
// accepting edge, and the chain step loads the result register once the
// output register is free.
// One request is taken every cycle as long as results are drained: the chain
// state feeds back through a combinational step, so consecutive applies run
// back to back, and a load is visible to an apply accepted the next cycle.
// A result with final_res set returns the chain and the cost to their start
// values. Table rows that were never loaded read as unknown.
module coupon_chain_expected_cost_core #(
    parameter int COLORS = 3,
    parameter int TESTS  = 20
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_command,
    input  ccec_pkg::idx_t   s_test_index,
    input  ccec_pkg::prob_t  s_prob_color0,
    input  ccec_pkg::prob_t  s_prob_color1,
    input  ccec_pkg::prob_t  s_prob_color2,
    input  logic             s_last,
    output logic             m_valid,
    input  logic             m_ready,
    output ccec_pkg::cost_t  m_expected_cost,
    output ccec_pkg::mass_t  m_finished_prob,
    output logic             m_final_res
);

    import ccec_pkg::*;

    localparam int SUBSETS = 2**COLORS;
    localparam int ADDR_W  = $clog2(TESTS);
    localparam int ROW_W   = COLORS * PROB_W;
    // Chain start: all mass on the empty subset
    localparam mass_t [SUBSETS-1:0] MASS_START = (SUBSETS*MASS_W)'(MASS_ONE);

    logic                       s_accept;
    logic                       in_range;
    logic                       load_we;
    logic                       apply_rd;
    prob_t [MAX_COLORS-1:0]     field_prob;
    prob_t [COLORS-1:0]         load_row;
    logic [ROW_W-1:0]           rd_row;
    prob_t [COLORS-1:0]         step_prob;

    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    logic                       s1_in_range_reg;
    logic                       s1_last_reg;
    logic                       s1_adv;

    mass_t [SUBSETS-1:0]        mass_reg;
    mass_t [SUBSETS-1:0]        mass_next;
    mass_t [SUBSETS-1:0]        step_mass;
    cost_t                      cost_reg;
    cost_t                      cost_next;
    cost_t                      step_cost;

    logic                       m_valid_reg;
    logic                       m_valid_next;
    cost_t                      m_cost_reg;
    mass_t                      m_finished_reg;
    logic                       m_final_reg;

    // Accept a request whenever the step stage is empty or moving on
    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || s1_adv;
    assign s_accept = s_valid && s_ready;
    assign in_range = 32'(s_test_index) < 32'(TESTS);
    assign load_we  = s_accept && (s_command == CMD_LOAD) && in_range;
    assign apply_rd = s_accept && (s_command == CMD_APPLY);

    // Clamp each loaded probability at one; colors without a field load zero
    assign field_prob[0] = s_prob_color0;
    assign field_prob[1] = s_prob_color1;
    assign field_prob[2] = s_prob_color2;
    assign field_prob[3] = '0;

    always_comb begin
        for (int c = 0; c < COLORS; c++) begin
            load_row[c] = (field_prob[c] > PROB_ONE) ? PROB_ONE : field_prob[c];
        end
    end

    ccec_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TESTS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (load_we),
        .wr_addr (ADDR_W'(s_test_index)),
        .wr_data (load_row),
        .rd_en   (apply_rd),
        .rd_addr (ADDR_W'(s_test_index)),
        .rd_data (rd_row)
    );

    // Out-of-range tests step with zero probability
    assign step_prob = s1_in_range_reg ? rd_row : '0;

    ccec_step #(
        .COLORS (COLORS)
    ) u_step (
        .prob     (step_prob),
        .mass_in  (mass_reg),
        .cost_in  (cost_reg),
        .mass_out (step_mass),
        .cost_out (step_cost)
    );

    // Hold the step stage until its result can move to the output
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (apply_rd) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
    end

    // Advance the chain on each result; restart it after the last test
    always_comb begin
        mass_next = mass_reg;
        cost_next = cost_reg;
        if (s1_adv) begin
            if (s1_last_reg) begin
                mass_next = MASS_START;
                cost_next = COST_ONE;
            end else begin
                mass_next = step_mass;
                cost_next = step_cost;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            mass_reg     <= MASS_START;
            cost_reg     <= COST_ONE;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            mass_reg     <= mass_next;
            cost_reg     <= cost_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (apply_rd) begin
            s1_in_range_reg <= in_range;
            s1_last_reg     <= s_last;
        end
        if (s1_adv) begin
            m_cost_reg     <= step_cost;
            m_finished_reg <= step_mass[SUBSETS-1];
            m_final_reg    <= s1_last_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_expected_cost = m_cost_reg;
    assign m_finished_prob = m_finished_reg;
    assign m_final_res     = m_final_reg;

    // A finished step always shows up as a result
    a_step_to_result : assert property (@(posedge aclk) disable iff (!aresetn)
        s1_adv |=> m_valid)
        else $error("step result did not reach the output");

    // The chain restarts after the closing test of an order
    a_restart : assert property (@(posedge aclk) disable iff (!aresetn)
        s1_adv && s1_last_reg |=> cost_reg == COST_ONE && mass_reg[0] == MASS_ONE)
        else $error("chain did not restart after last");

    // Results stay within their saturation limits
    a_result_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_finished_prob <= MASS_ONE && m_expected_cost <= COST_MAX
            && m_expected_cost >= COST_ONE)
        else $error("result out of range");

endmodule

### sim/coupon_chain_expected_cost_core_test.sv
module coupon_chain_expected_cost_core_test;
    import ccec_pkg::*;

    localparam int COLORS      = 3;
    localparam int TESTS       = 20;
    localparam int SUBSETS     = 1 << COLORS;
    localparam int FULL_SET    = SUBSETS - 1;
    localparam int RAND_ITEMS  = 1500;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 8;

    // One request, plus an optional hand-typed result for directed rows
    typedef struct packed {
        logic  cmd;
        idx_t  idx;
        prob_t p0;
        prob_t p1;
        prob_t p2;
        logic  last;
        logic  typed;
        cost_t cost;
        mass_t fin;
    } req_row_t;

    typedef struct packed {
        cost_t cost;
        mass_t fin;
        logic  closes;
    } chain_result_t;

    logic  aclk          = 1'b0;
    logic  aresetn       = 1'b0;
    logic  s_valid       = 1'b0;
    logic  s_ready;
    logic  s_command     = CMD_LOAD;
    idx_t  s_test_index  = '0;
    prob_t s_prob_color0 = '0;
    prob_t s_prob_color1 = '0;
    prob_t s_prob_color2 = '0;
    logic  s_last        = 1'b0;
    logic  m_valid;
    logic  m_ready       = 1'b1;
    cost_t m_expected_cost;
    mass_t m_finished_prob;
    logic  m_final_res;

    // Chain shadow: table, subset masses and running cost
    prob_t prob_rows [TESTS][COLORS];
    mass_t subset_mass [SUBSETS];
    cost_t running_cost;

    chain_result_t results_due [$];

    int errors       = 0;
    int cycles       = 0;
    int burst_left   = 0;
    int n_loads      = 0;
    int n_applies    = 0;
    int n_closed     = 0;
    int n_cost_sat   = 0;
    int n_full_sat   = 0;
    int n_checked    = 0;

    // Directed requests: extremes, out-of-range indexes, saturation
    req_row_t directed_rows [0:24] = '{
        '{CMD_APPLY, 5'd31, 17'd0, 17'd0, 17'd0, 1'b1, 1'b1, COST_ONE, 25'd0},
        '{CMD_LOAD,  5'd0,  PROB_ONE, PROB_ONE, PROB_ONE, 1'b1, 1'b0, '0, '0},
        '{CMD_LOAD,  5'd1,  17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 1'b0, 1'b0, '0, '0},
        '{CMD_LOAD,  5'd2,  17'd0, 17'd0, 17'd0, 1'b0, 1'b0, '0, '0},
        '{CMD_LOAD,  5'd25, 17'h1FFFF, 17'd7, 17'd0, 1'b1, 1'b0, '0, '0},
        '{CMD_LOAD,  5'd19, 17'd32768, 17'd16384, 17'd8192, 1'b0, 1'b0, '0, '0},
        '{CMD_LOAD,  5'd3,  17'd65535, 17'd1, 17'd43690, 1'b0, 1'b0, '0, '0},
        '{CMD_APPLY, 5'd0,  17'd0, 17'd0, 17'd0, 1'b1, 1'b1, 31'd67108864, 25'd0},
        '{CMD_APPLY, 5'd1,  17'd0, 17'd0, 17'd0, 1'b0, 1'b0, '0, '0},
        '{CMD_APPLY, 5'd1,  17'd0, 17'd0, 17'd0, 1'b0, 1'b0, '0, '0},
        '{CMD_APPLY, 5'd1,  17'd0, 17'd0, 17'd0, 1'b0, 1'b0, '0, '0},
        '{CMD_APPLY, 5'd1,  17'd0, 17'd0, 17'd0, 1'b0, 1'b0, '0, '0},
        '{CMD_APPLY, 5'd1,  17'd0, 17'd0, 17'd0, 1'b0, 1'b0, '0, '0},
        '{CMD_APPLY, 5'd1,  17'd0, 17'd0, 17'd0, 1'b0, 1'b0, '0, '0},
        '{CMD_APPLY, 5'd1,  17'd0, 17'd0, 17'd0, 1'b0, 1'b0, '0, '0},
        '{CMD_APPLY, 5'd1,  17'd0, 17'd0, 17'd0, 1'b0, 1'b0, '0, '0},
        '{CMD_APPLY, 5'd1,  17'd0, 17'd0, 17'd0, 1'b0, 1'b0, '0, '0},
        '{CMD_APPLY, 5'd1,  17'd0, 17'd0, 17'd0, 1'b0, 1'b0, '0, '0},
        '{CMD_APPLY, 5'd1,  17'd0, 17'd0, 17'd0, 1'b0, 1'b0, '0, '0},
        '{CMD_APPLY, 5'd1,  17'd0, 17'd0, 17'd0, 1'b1, 1'b1, COST_MAX, MASS_ONE},
        '{CMD_APPLY, 5'd20, 17'd0, 17'd0, 17'd0, 1'b1, 1'b1, COST_ONE, 25'd0},
        '{CMD_APPLY, 5'd19, 17'd0, 17'd0, 17'd0, 1'b0, 1'b0, '0, '0},
        '{CMD_APPLY, 5'd2,  17'd0, 17'd0, 17'd0, 1'b0, 1'b0, '0, '0},
        '{CMD_APPLY, 5'd3,  17'd0, 17'd0, 17'd0, 1'b0, 1'b0, '0, '0},
        '{CMD_APPLY, 5'd19, 17'd0, 17'd0, 17'd0, 1'b1, 1'b0, '0, '0}
    };

    coupon_chain_expected_cost_core #(
        .COLORS (COLORS),
        .TESTS  (TESTS)
    ) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_test_index    (s_test_index),
        .s_prob_color0   (s_prob_color0),
        .s_prob_color1   (s_prob_color1),
        .s_prob_color2   (s_prob_color2),
        .s_last          (s_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_expected_cost (m_expected_cost),
        .m_finished_prob (m_finished_prob),
        .m_final_res     (m_final_res)
    );

    always #1 aclk = ~aclk;

    // Put the chain back to its start: all mass on the empty subset, cost one
    function automatic void restart_chain();
        for (int s = 0; s < SUBSETS; s++) begin
            subset_mass[s] = '0;
        end
        subset_mass[0] = MASS_ONE;
        running_cost   = COST_ONE;
    endfunction

    // Update the shadow for one accepted request and queue its result
    function automatic void track_request(input req_row_t r);
        prob_t         pin [COLORS];
        mass_t         fresh [SUBSETS];
        chain_result_t want;
        logic [63:0]   acc;
        logic [63:0]   m;
        logic [63:0]   sum;
        logic [63:0]   p;
        pin[0] = r.p0;
        pin[1] = r.p1;
        pin[2] = r.p2;
        if (r.cmd == CMD_LOAD) begin
            n_loads++;
            // Clamp to one; rows past the table are dropped
            if (r.idx < TESTS) begin
                for (int c = 0; c < COLORS; c++) begin
                    prob_rows[r.idx][c] = (pin[c] > PROB_ONE) ? PROB_ONE : pin[c];
                end
            end
            return;
        end
        n_applies++;
        fresh[0] = '0;
        for (int s = 1; s < SUBSETS; s++) begin
            acc = '0;
            for (int c = 0; c < COLORS; c++) begin
                if (s[c]) begin
                    p = (r.idx < TESTS) ? 64'(prob_rows[r.idx][c]) : 64'd0;
                    acc += p * (64'(subset_mass[s ^ (1 << c)]) + 64'(subset_mass[s]));
                end
            end
            // Round once to Q1.24, then clamp to one
            m = (acc + ROUND_HALF) >> ROUND_SHIFT;
            if (m > MASS_ONE) m = MASS_ONE;
            fresh[s] = mass_t'(m);
            if (s != FULL_SET) begin
                sum = 64'(running_cost) + m;
                running_cost = (sum > COST_MAX) ? COST_MAX : cost_t'(sum);
            end
        end
        for (int s = 0; s < SUBSETS; s++) begin
            subset_mass[s] = fresh[s];
        end
        want.cost   = running_cost;
        want.fin    = subset_mass[FULL_SET];
        want.closes = r.last;
        if (r.typed) begin
            want.cost = r.cost;
            want.fin  = r.fin;
        end
        if (want.cost == COST_MAX) n_cost_sat++;
        if (want.fin == MASS_ONE) n_full_sat++;
        if (r.last) begin
            n_closed++;
            restart_chain();
        end
        results_due.push_back(want);
    endfunction

    // Random probability: zero, one, above one, tiny or mid-range
    function automatic prob_t rand_prob();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return PROB_ONE;
            2:       return prob_t'($urandom_range(65537, 131071));
            3:       return prob_t'($urandom_range(0, 4096));
            default: return prob_t'($urandom_range(0, 32768));
        endcase
    endfunction

    // Drop valid between bursts for a random gap; now and then a long burst
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap        = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Present one request and hold it until the block takes it
    task automatic send_request(input req_row_t r);
        s_valid       <= 1'b1;
        s_command     <= r.cmd;
        s_test_index  <= r.idx;
        s_prob_color0 <= r.p0;
        s_prob_color1 <= r.p1;
        s_prob_color2 <= r.p2;
        s_last        <= r.last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        track_request(r);
        pace_sender();
    endtask

    // Stall the result side: free-running, coin flips, a fixed duty, or slow
    always @(posedge aclk) begin : stall_results
        int mode;
        mode = (cycles / 97) % 4;
        case (mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            2:       m_ready <= ((cycles % 8) >= 3);
            default: m_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    // Compare each result with the oldest one due
    always @(posedge aclk) begin : check_results
        chain_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (results_due.size() == 0) begin
                $display("%0t: result with nothing due: cost %0d finished %0d final %0b",
                         $time, m_expected_cost, m_finished_prob, m_final_res);
                errors++;
            end else begin
                want = results_due.pop_front();
                n_checked++;
                if (m_expected_cost !== want.cost) begin
                    $display("%0t: expected_cost expected %0d actual %0d",
                             $time, want.cost, m_expected_cost);
                    errors++;
                end
                if (m_finished_prob !== want.fin) begin
                    $display("%0t: finished_prob expected %0d actual %0d",
                             $time, want.fin, m_finished_prob);
                    errors++;
                end
                if (m_final_res !== want.closes) begin
                    $display("%0t: final_res expected %0b actual %0b",
                             $time, want.closes, m_final_res);
                    errors++;
                end
            end
        end
    end

    // Bound the run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results due", $time, results_due.size());
            $display("coupon_chain_expected_cost_core_test: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        req_row_t r;
        int       sent;
        int       order_len;
        restart_chain();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table
        foreach (directed_rows[i]) begin
            send_request(directed_rows[i]);
        end

        // Fill every row so that no apply reads an unwritten entry
        sent = 0;
        for (int t = 0; t < TESTS; t++) begin
            r       = '0;
            r.cmd   = CMD_LOAD;
            r.idx   = idx_t'(t);
            r.p0    = rand_prob();
            r.p1    = rand_prob();
            r.p2    = rand_prob();
            r.last  = 1'($urandom_range(0, 1));
            send_request(r);
            sent++;
        end

        // Random orders of applies, with reloads and stray requests mixed in
        while (sent < RAND_ITEMS) begin
            order_len = $urandom_range(1, 12);
            for (int k = 0; k < order_len; k++) begin
                r    = '0;
                r.p0 = rand_prob();
                r.p1 = rand_prob();
                r.p2 = rand_prob();
                if ($urandom_range(0, 6) == 0) begin
                    r.cmd  = CMD_LOAD;
                    r.idx  = idx_t'($urandom_range(0, 31));
                    r.last = 1'($urandom_range(0, 1));
                end else begin
                    r.cmd  = CMD_APPLY;
                    r.idx  = ($urandom_range(0, 9) == 0) ? idx_t'($urandom_range(TESTS, 31))
                                                         : idx_t'($urandom_range(0, TESTS - 1));
                    r.last = (k == order_len - 1) ? ($urandom_range(0, 11) != 0) : 1'b0;
                end
                send_request(r);
                sent++;
            end
        end
        s_valid <= 1'b0;

        // Drain outstanding results, then let the pipeline settle
        while (results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Sent %0d loads and %0d applies; %0d orders closed, %0d results checked.",
                 n_loads, n_applies, n_closed, n_checked);
        $display("Cost hit its ceiling %0d times, full-set mass hit one %0d times.",
                 n_cost_sat, n_full_sat);
        if (errors == 0) begin
            $display("coupon_chain_expected_cost_core_test: PASS");
        end else begin
            $display("coupon_chain_expected_cost_core_test: FAIL");
        end
        $finish;
    end

endmodule
